FILE: rtl/mfb_pkg.sv
package mfb_pkg;

   localparam int PANEL_WIDTH  = 400;
   localparam int PANEL_HEIGHT = 300;
   localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
   localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
   localparam int STORE_AW     = $clog2(STORE_BYTES);

   localparam logic [1:0] ACT_IMAGE = 2'd0;
   localparam logic [1:0] ACT_PIXEL = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam logic [1:0] CSR_IMAGE_LEFT    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_TOP     = 2'd1;
   localparam logic [1:0] CSR_IMAGE_COLUMNS = 2'd2;
   localparam logic [1:0] CSR_IMAGE_ROWS    = 2'd3;

   typedef logic [STORE_AW-1:0] addr_type;
   typedef logic [7:0]          byte_type;

   typedef struct packed {
      byte_type    mask;
      logic [2:0]  shift;
      logic        second;
   } merge_ctrl_type;

endpackage

FILE: rtl/mfb_store.sv
module mfb_store (
   input  logic               clock,
   input  logic               wr_en,
   input  mfb_pkg::addr_type  wr_addr,
   input  mfb_pkg::byte_type  wr_data,
   input  logic               rd_en,
   input  mfb_pkg::addr_type  rd_addr,
   output mfb_pkg::byte_type  rd_data
);

   mfb_pkg::byte_type mem_ff [mfb_pkg::STORE_BYTES];
   mfb_pkg::byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mfb_merge.sv
module mfb_merge (
   input  mfb_pkg::merge_ctrl_type  ctrl,
   input  mfb_pkg::byte_type        src_bits,
   input  mfb_pkg::byte_type        old_byte,
   output mfb_pkg::byte_type        new_byte,
   output logic                     touch
);

   logic [15:0]       data_wide;
   logic [15:0]       mask_wide;
   mfb_pkg::byte_type data_sel;
   mfb_pkg::byte_type mask_sel;

   // the source byte spans the target byte and the one to its right
   assign data_wide = {src_bits, 8'h00} >> ctrl.shift;
   assign mask_wide = {ctrl.mask, 8'h00} >> ctrl.shift;
   assign data_sel  = ctrl.second ? data_wide[7:0] : data_wide[15:8];
   assign mask_sel  = ctrl.second ? mask_wide[7:0] : mask_wide[15:8];
   assign new_byte  = (old_byte & ~mask_sel) | (data_sel & mask_sel);
   assign touch     = |mask_sel;

endmodule

FILE: rtl/mono_framebuffer_blitter_unit.sv
// One-bit-per-pixel framebuffer blitter. A request is taken when start is high
// and busy is low; exactly one response follows, shown for one cycle on
// rsp_strobe, and the receiver cannot stall it. An image byte or a set pixel
// is done as one read-modify-write pass through the single-port-pair store
// for each of the two framebuffer bytes a source byte can cover. A read
// goes through S_RD_ONE and S_RD_DATA. A fill writes every byte of the store,
// one byte a cycle, before its response.
// Configuration writes are always accepted and must only be issued while idle.
module mono_framebuffer_blitter_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_source_bits,
   input  logic               req_image_begin,
   input  logic signed [10:0] req_dot_column,
   input  logic signed [10:0] req_dot_row,
   input  logic               req_dot_white,
   input  logic [13:0]        req_read_address,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_read_byte,
   output logic               rsp_image_complete,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_data
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_BASE    = 4'd1;
   localparam logic [3:0] S_RD_A    = 4'd2;
   localparam logic [3:0] S_WR_A    = 4'd3;
   localparam logic [3:0] S_RD_B    = 4'd4;
   localparam logic [3:0] S_WR_B    = 4'd5;
   localparam logic [3:0] S_FILL    = 4'd6;
   localparam logic [3:0] S_RD_ONE  = 4'd7;
   localparam logic [3:0] S_RD_DATA = 4'd8;
   localparam logic [3:0] S_RESP    = 4'd9;

   logic [3:0]  state_ff, state_in;

   logic [10:0] image_left_ff;
   logic [10:0] image_top_ff;
   logic [9:0]  image_columns_ff;
   logic [9:0]  image_rows_ff;

   logic [9:0]  source_row_ff, source_row_in;
   logic [6:0]  source_byte_column_ff, source_byte_column_in;

   // per-request working registers
   logic                kind_image_ff;
   logic                active_ff;
   logic [12:0]         x0_ff;
   logic [11:0]         y0_ff;
   logic [6:0]          col_byte_ff;
   mfb_pkg::byte_type   bits_ff;
   mfb_pkg::byte_type   mask_ff, mask_in;
   mfb_pkg::addr_type   row_base_ff, row_base_in;
   mfb_pkg::addr_type   fill_ff;
   logic [13:0]         rd_addr_ff;
   logic                complete_ff;
   mfb_pkg::byte_type   result_ff;

   logic        accept;
   logic [9:0]  row_eff;
   logic [6:0]  col_eff;
   logic [7:0]  row_bytes_src;
   logic [7:0]  col_next;
   logic        image_active;
   logic        row_done;
   logic [9:0]  row_next;

   mfb_pkg::merge_ctrl_type merge_ctrl;
   mfb_pkg::byte_type       merged;
   logic                    touch;
   mfb_pkg::addr_type       cur_addr;
   logic                    read_in_range;

   logic                    st_wr_en;
   mfb_pkg::addr_type       st_wr_addr;
   mfb_pkg::byte_type       st_wr_data;
   logic                    st_rd_en;
   mfb_pkg::addr_type       st_rd_addr;
   mfb_pkg::byte_type       st_rd_data;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // source position counters, cleared first when a new image begins
   always_comb begin
      row_eff       = req_image_begin ? 10'd0 : source_row_ff;
      col_eff       = req_image_begin ? 7'd0  : source_byte_column_ff;
      row_bytes_src = 8'(({1'b0, image_columns_ff} + 11'd7) >> 3);
      col_next      = {1'b0, col_eff} + 8'd1;
      image_active  = (image_columns_ff != 10'd0) && (row_eff < image_rows_ff);
      row_done      = (col_next >= row_bytes_src);
      row_next      = row_eff + 10'd1;
      source_row_in         = source_row_ff;
      source_byte_column_in = source_byte_column_ff;
      if (accept && req_action == mfb_pkg::ACT_IMAGE) begin
         source_row_in         = row_eff;
         source_byte_column_in = col_eff;
         if (image_active) begin
            if (row_done) begin
               source_byte_column_in = 7'd0;
               source_row_in         = row_next;
            end else begin
               source_byte_column_in = col_next[6:0];
            end
         end
      end
   end

   // which source bits land on the panel
   always_comb begin
      logic [12:0] xb;
      logic [10:0] cb;
      logic        xin;
      logic        yin;
      logic        cok;
      mask_in = '0;
      yin = !y0_ff[11] && ({1'b0, y0_ff[10:0]} < 12'(mfb_pkg::PANEL_HEIGHT));
      for (int b = 0; b < 8; b++) begin
         xb  = x0_ff + 13'(b);
         cb  = 11'({col_byte_ff, 3'b000}) + 11'(b);
         xin = !xb[12] && (xb < 13'(mfb_pkg::PANEL_WIDTH));
         cok = kind_image_ff ? (cb < {1'b0, image_columns_ff}) : (b == 0);
         mask_in[7 - b] = active_ff && cok && xin && yin;
      end
      row_base_in = mfb_pkg::STORE_AW'(32'(y0_ff[10:0]) * mfb_pkg::ROW_BYTES);
   end

   assign merge_ctrl.mask   = mask_ff;
   assign merge_ctrl.shift  = x0_ff[2:0];
   assign merge_ctrl.second = (state_ff == S_RD_B) || (state_ff == S_WR_B);

   mfb_merge u_merge (
      .ctrl     (merge_ctrl),
      .src_bits (bits_ff),
      .old_byte (st_rd_data),
      .new_byte (merged),
      .touch    (touch)
   );

   // byte column of the leftmost pixel is -1 when the image starts just left of the panel
   assign cur_addr = row_base_ff + mfb_pkg::STORE_AW'(signed'(x0_ff[12:3]))
                   + mfb_pkg::STORE_AW'(merge_ctrl.second);
   assign read_in_range = (rd_addr_ff < 14'(mfb_pkg::STORE_BYTES));

   always_comb begin
      st_wr_en   = 1'b0;
      st_wr_addr = cur_addr;
      st_wr_data = merged;
      st_rd_en   = 1'b0;
      st_rd_addr = cur_addr;
      case (state_ff)
         S_RD_A, S_RD_B: begin
            st_rd_en = touch;
         end
         S_WR_A, S_WR_B: begin
            st_wr_en = touch;
         end
         S_FILL: begin
            st_wr_en   = 1'b1;
            st_wr_addr = fill_ff;
            st_wr_data = bits_ff;
         end
         S_RD_ONE: begin
            st_rd_en   = read_in_range;
            st_rd_addr = mfb_pkg::STORE_AW'(rd_addr_ff);
         end
         default: begin
         end
      endcase
   end

   mfb_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  mfb_pkg::ACT_IMAGE: state_in = S_BASE;
                  mfb_pkg::ACT_PIXEL: state_in = S_BASE;
                  mfb_pkg::ACT_FILL:  state_in = S_FILL;
                  default:            state_in = S_RD_ONE;
               endcase
            end
         end
         S_BASE:    state_in = S_RD_A;
         S_RD_A:    state_in = S_WR_A;
         S_WR_A:    state_in = S_RD_B;
         S_RD_B:    state_in = S_WR_B;
         S_WR_B:    state_in = S_RESP;
         S_FILL: begin
            if (fill_ff == mfb_pkg::STORE_AW'(mfb_pkg::STORE_BYTES - 1)) begin
               state_in = S_RESP;
            end
         end
         S_RD_ONE:  state_in = S_RD_DATA;
         S_RD_DATA: state_in = S_RESP;
         S_RESP:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= S_IDLE;
         image_left_ff         <= '0;
         image_top_ff          <= '0;
         image_columns_ff      <= '0;
         image_rows_ff         <= '0;
         source_row_ff         <= '0;
         source_byte_column_ff <= '0;
      end else begin
         state_ff              <= state_in;
         source_row_ff         <= source_row_in;
         source_byte_column_ff <= source_byte_column_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mfb_pkg::CSR_IMAGE_LEFT:    image_left_ff    <= csr_data;
               mfb_pkg::CSR_IMAGE_TOP:     image_top_ff     <= csr_data;
               mfb_pkg::CSR_IMAGE_COLUMNS: image_columns_ff <= csr_data[9:0];
               mfb_pkg::CSR_IMAGE_ROWS:    image_rows_ff    <= csr_data[9:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_image_ff <= (req_action == mfb_pkg::ACT_IMAGE);
         rd_addr_ff    <= req_read_address;
         fill_ff       <= '0;
         result_ff     <= '0;
         if (req_action == mfb_pkg::ACT_IMAGE) begin
            active_ff   <= image_active;
            x0_ff       <= {{2{image_left_ff[10]}}, image_left_ff}
                         + 13'({col_eff, 3'b000});
            y0_ff       <= {image_top_ff[10], image_top_ff} + {2'b00, row_eff};
            col_byte_ff <= col_eff;
            bits_ff     <= req_source_bits;
            complete_ff <= image_active && row_done && (row_next >= image_rows_ff);
         end else begin
            active_ff   <= 1'b1;
            x0_ff       <= {{2{req_dot_column[10]}}, req_dot_column};
            y0_ff       <= {req_dot_row[10], req_dot_row};
            col_byte_ff <= '0;
            bits_ff     <= {8{req_dot_white}};
            complete_ff <= 1'b0;
         end
      end
      if (state_ff == S_BASE) begin
         mask_ff     <= mask_in;
         row_base_ff <= row_base_in;
      end
      if (state_ff == S_FILL) begin
         fill_ff <= fill_ff + mfb_pkg::STORE_AW'(1);
      end
      if (state_ff == S_RD_DATA) begin
         result_ff <= read_in_range ? st_rd_data : 8'h00;
      end
   end

   assign rsp_strobe         = (state_ff == S_RESP);
   assign rsp_read_byte      = result_ff;
   assign rsp_image_complete = complete_ff;

endmodule

FILE: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_GOAL    = 1200;
   localparam int CALM_TAIL    = 150;
   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         source_bits;
      logic               image_begin;
      logic signed [10:0] dot_column;
      logic signed [10:0] dot_row;
      logic               dot_white;
      logic [13:0]        read_address;
   } blit_request_type;

   typedef struct packed {
      mfb_pkg::byte_type read_byte;
      logic              image_complete;
   } blit_reply_type;

   // shadow copy of the panel plus the predicted replies not yet checked
   class panel_shadow;
      mfb_pkg::byte_type  pixels[mfb_pkg::STORE_BYTES];
      logic signed [10:0] left_reg;
      logic signed [10:0] top_reg;
      logic [9:0]         columns_reg;
      logic [9:0]         rows_reg;
      int                 source_row;
      int                 source_column;
      blit_reply_type     owed_replies[$];
      int                 mismatches;

      function new();
         left_reg      = '0;
         top_reg       = '0;
         columns_reg   = '0;
         rows_reg      = '0;
         source_row    = 0;
         source_column = 0;
         mismatches    = 0;
      endfunction

      function int pending();
         return owed_replies.size();
      endfunction

      function void set_register(logic [1:0] index, logic [10:0] value);
         case (index)
            mfb_pkg::CSR_IMAGE_LEFT:    left_reg    = value;
            mfb_pkg::CSR_IMAGE_TOP:     top_reg     = value;
            mfb_pkg::CSR_IMAGE_COLUMNS: columns_reg = value[9:0];
            mfb_pkg::CSR_IMAGE_ROWS:    rows_reg    = value[9:0];
            default: begin
            end
         endcase
      endfunction

      function void put_pixel(int x, int y, logic white);
         int                idx;
         mfb_pkg::byte_type mask;
         if (x < 0 || x >= mfb_pkg::PANEL_WIDTH || y < 0 || y >= mfb_pkg::PANEL_HEIGHT)
            return;
         idx  = y * mfb_pkg::ROW_BYTES + (x >>> 3);
         mask = 8'h80 >> (x & 7);
         if (white)
            pixels[idx] = pixels[idx] | mask;
         else
            pixels[idx] = pixels[idx] & ~mask;
      endfunction

      // returns 1 when this byte closes the last source row
      function logic draw_source_byte(mfb_pkg::byte_type bits, logic fresh);
         int cols;
         int rows;
         int left;
         int top;
         int row_bytes;
         int c;
         cols = int'(columns_reg);
         rows = int'(rows_reg);
         left = int'(left_reg);
         top  = int'(top_reg);
         if (fresh) begin
            source_row    = 0;
            source_column = 0;
         end
         if (cols == 0 || source_row >= rows)
            return 1'b0;
         row_bytes = (cols + 7) >> 3;
         for (int b = 0; b < 8; b++) begin
            c = source_column * 8 + b;
            if (c < cols)
               put_pixel(left + c, top + source_row, bits[7 - b]);
         end
         source_column = (source_column + 1) & 'hFF;
         if (source_column >= row_bytes) begin
            source_column = 0;
            source_row    = (source_row + 1) & 'h3FF;
            if (source_row >= rows)
               return 1'b1;
         end
         source_column = source_column & 'h7F;
         return 1'b0;
      endfunction

      function void take_request(blit_request_type req);
         blit_reply_type reply;
         reply = '0;
         case (req.action)
            mfb_pkg::ACT_IMAGE:
               reply.image_complete = draw_source_byte(req.source_bits, req.image_begin);
            mfb_pkg::ACT_PIXEL:
               put_pixel(int'(req.dot_column), int'(req.dot_row), req.dot_white);
            mfb_pkg::ACT_FILL:
               foreach (pixels[i]) pixels[i] = {8{req.dot_white}};
            default: begin
               if (req.read_address < 14'(mfb_pkg::STORE_BYTES))
                  reply.read_byte = pixels[req.read_address];
            end
         endcase
         owed_replies.push_back(reply);
      endfunction

      task report_mismatch(string what);
         if (mismatches < REPORT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_reply(mfb_pkg::byte_type read_byte, logic image_complete);
         blit_reply_type want;
         if (owed_replies.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = owed_replies.pop_front();
         if (read_byte !== want.read_byte)
            report_mismatch($sformatf("read_byte %h, predicted %h", read_byte, want.read_byte));
         if (image_complete !== want.image_complete)
            report_mismatch($sformatf("image_complete %b, predicted %b",
                                      image_complete, want.image_complete));
      endtask
   endclass

   logic               clock;
   logic               reset              = 1'b1;
   logic               start              = 1'b0;
   logic               busy;
   logic [1:0]         req_action         = mfb_pkg::ACT_READ;
   logic [7:0]         req_source_bits    = '0;
   logic               req_image_begin    = 1'b0;
   logic signed [10:0] req_dot_column     = '0;
   logic signed [10:0] req_dot_row        = '0;
   logic               req_dot_white      = 1'b0;
   logic [13:0]        req_read_address   = '0;
   logic               rsp_strobe;
   logic [7:0]         rsp_read_byte;
   logic               rsp_image_complete;
   logic               csr_valid          = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index          = mfb_pkg::CSR_IMAGE_LEFT;
   logic [10:0]        csr_data           = '0;

   panel_shadow board = new();

   int sent       = 0;
   int fills_left = 12;
   bit gappy      = 1'b1;
   int cfg_left   = 0;
   int cfg_top    = 0;
   int cfg_cols   = 0;
   int cfg_rows   = 0;

   mono_framebuffer_blitter_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_source_bits    (req_source_bits),
      .req_image_begin    (req_image_begin),
      .req_dot_column     (req_dot_column),
      .req_dot_row        (req_dot_row),
      .req_dot_white      (req_dot_white),
      .req_read_address   (req_read_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_image_complete (rsp_image_complete),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_reply(rsp_read_byte, rsp_image_complete);
   end

   function automatic blit_request_type noise();
      blit_request_type r;
      r.action       = 2'($urandom_range(0, 3));
      r.source_bits  = 8'($urandom);
      r.image_begin  = 1'($urandom_range(0, 1));
      r.dot_column   = 11'($urandom);
      r.dot_row      = 11'($urandom);
      r.dot_white    = 1'($urandom_range(0, 1));
      r.read_address = 14'($urandom);
      return r;
   endfunction

   function automatic blit_request_type image_req(mfb_pkg::byte_type bits, logic fresh);
      blit_request_type r;
      r             = noise();
      r.action      = mfb_pkg::ACT_IMAGE;
      r.source_bits = bits;
      r.image_begin = fresh;
      return r;
   endfunction

   function automatic blit_request_type pixel_req(int x, int y, logic white);
      blit_request_type r;
      r            = noise();
      r.action     = mfb_pkg::ACT_PIXEL;
      r.dot_column = 11'(x);
      r.dot_row    = 11'(y);
      r.dot_white  = white;
      return r;
   endfunction

   function automatic blit_request_type fill_req(logic white);
      blit_request_type r;
      r           = noise();
      r.action    = mfb_pkg::ACT_FILL;
      r.dot_white = white;
      return r;
   endfunction

   function automatic blit_request_type read_req(int addr);
      blit_request_type r;
      r              = noise();
      r.action       = mfb_pkg::ACT_READ;
      r.read_address = 14'(addr);
      return r;
   endfunction

   function automatic mfb_pkg::byte_type pick_bits();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // a store byte somewhere under the current image, clamped onto the panel
   function automatic int image_area_address();
      int x;
      int y;
      x = cfg_left + int'($urandom_range(0, cfg_cols));
      y = cfg_top + int'($urandom_range(0, cfg_rows));
      if (x < 0)
         x = 0;
      if (x >= mfb_pkg::PANEL_WIDTH)
         x = mfb_pkg::PANEL_WIDTH - 1;
      if (y < 0)
         y = 0;
      if (y >= mfb_pkg::PANEL_HEIGHT)
         y = mfb_pkg::PANEL_HEIGHT - 1;
      return y * mfb_pkg::ROW_BYTES + x / 8;
   endfunction

   function automatic int pick_read_address();
      int pick;
      pick = int'($urandom_range(0, 19));
      if (pick < 3)
         return int'($urandom_range(mfb_pkg::STORE_BYTES, 16383));
      else if (pick < 8)
         return int'($urandom_range(0, mfb_pkg::STORE_BYTES - 1));
      else
         return image_area_address();
   endfunction

   function automatic int place(int span);
      case ($urandom_range(0, 7))
         0:       return -1024;
         1:       return 1023;
         2:       return int'($urandom_range(0, 2047)) - 1024;
         3:       return span - int'($urandom_range(1, 16));
         4:       return -int'($urandom_range(0, 15));
         default: return int'($urandom_range(0, span - 1));
      endcase
   endfunction

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send(blit_request_type req);
      if (gappy && sent < ITEM_GOAL - CALM_TAIL && $urandom_range(0, 3) == 0)
         pause(int'($urandom_range(1, 12)));
      req_action       <= req.action;
      req_source_bits  <= req.source_bits;
      req_image_begin  <= req.image_begin;
      req_dot_column   <= req.dot_column;
      req_dot_row      <= req.dot_row;
      req_dot_white    <= req.dot_white;
      req_read_address <= req.read_address;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      board.take_request(req);
      sent++;
   endtask

   task automatic send_noise();
      blit_request_type r;
      r = noise();
      if (r.action == mfb_pkg::ACT_FILL) begin
         if (fills_left > 0)
            fills_left--;
         else
            r.action = mfb_pkg::ACT_READ;
      end
      send(r);
   endtask

   task automatic send_side_request();
      int pick;
      pick = int'($urandom_range(0, 9));
      if (pick < 6)
         send(read_req(pick_read_address()));
      else if (pick < 8)
         send(pixel_req(cfg_left - 2 + int'($urandom_range(0, cfg_cols + 4)),
                        cfg_top - 2 + int'($urandom_range(0, cfg_rows + 4)),
                        1'($urandom_range(0, 1))));
      else
         send_noise();
   endtask

   // hold off until every predicted response is back
   task automatic settle();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, value);
   endtask

   task automatic configure(int left, int top, int cols, int rows);
      settle();
      cfg_left = left;
      cfg_top  = top;
      cfg_cols = cols;
      cfg_rows = rows;
      write_register(mfb_pkg::CSR_IMAGE_LEFT, left[10:0]);
      write_register(mfb_pkg::CSR_IMAGE_TOP, top[10:0]);
      write_register(mfb_pkg::CSR_IMAGE_COLUMNS, {($urandom_range(0, 1) == 1), cols[9:0]});
      write_register(mfb_pkg::CSR_IMAGE_ROWS, {($urandom_range(0, 1) == 1), rows[9:0]});
      csr_valid <= 1'b0;
   endtask

   // streams one image; large ones are cut short and left open
   task automatic draw_image(bit fresh);
      int total;
      int count;
      total = ((cfg_cols + 7) / 8) * cfg_rows;
      if (total == 0)
         count = int'($urandom_range(1, 4));
      else if (total > 260)
         count = int'($urandom_range(20, 160));
      else
         count = total;
      for (int k = 0; k < count && sent < ITEM_GOAL; k++) begin
         send(image_req(pick_bits(), fresh && k == 0));
         if ($urandom_range(0, 7) == 0)
            send_side_request();
      end
      // trailing bytes after the image is done must be dropped
      repeat ($urandom_range(0, 2)) send(image_req(8'($urandom), 1'b0));
      repeat ($urandom_range(2, 6)) send(read_req(image_area_address()));
   endtask

   task automatic random_phase();
      int shape;
      int cols;
      int rows;
      shape = int'($urandom_range(0, 9));
      if (shape == 0) begin
         cols = 1023;
         rows = int'($urandom_range(1, 2));
      end else if (shape == 1) begin
         cols = int'($urandom_range(1, 8));
         rows = 1023;
      end else if (shape == 2) begin
         cols = 0;
         rows = int'($urandom_range(0, 1023));
      end else if (shape == 3) begin
         cols = int'($urandom_range(1, 1023));
         rows = 0;
      end else begin
         cols = int'($urandom_range(1, 40));
         rows = int'($urandom_range(1, 8));
      end
      configure(place(mfb_pkg::PANEL_WIDTH), place(mfb_pkg::PANEL_HEIGHT), cols, rows);
      gappy = $urandom_range(0, 3) != 0;
      if (fills_left > 0 && $urandom_range(0, 19) == 0) begin
         fills_left--;
         send(fill_req(1'($urandom_range(0, 1))));
      end
      for (int n = 0; n < $urandom_range(1, 3); n++)
         draw_image(n > 0 || $urandom_range(0, 4) != 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // the store is undefined until written, so fill before any in-range read
      send(fill_req(1'b1));
      send(read_req(0));
      send(read_req(mfb_pkg::STORE_BYTES - 1));
      send(read_req(mfb_pkg::STORE_BYTES));
      send(read_req(16383));
      send(image_req(8'hFF, 1'b1));
      send(pixel_req(0, 0, 1'b0));
      send(pixel_req(mfb_pkg::PANEL_WIDTH - 1, mfb_pkg::PANEL_HEIGHT - 1, 1'b0));
      send(pixel_req(-1024, -1024, 1'b1));
      send(pixel_req(1023, 1023, 1'b0));
      send(pixel_req(mfb_pkg::PANEL_WIDTH, 0, 1'b0));
      send(pixel_req(0, mfb_pkg::PANEL_HEIGHT, 1'b0));
      begin
         blit_request_type r;
         r             = pixel_req(1, 0, 1'b0);
         r.image_begin = 1'b1;
         send(r);
      end
      send(read_req(0));
      send(read_req(mfb_pkg::STORE_BYTES - 1));
      send(fill_req(1'b0));
      send(read_req(7));

      // small image hanging off the top left corner, with padding bits
      configure(-3, -1, 13, 3);
      send(image_req(8'hFF, 1'b1));
      send(image_req(8'hFF, 1'b0));
      send(image_req(8'hA5, 1'b0));
      send(image_req(8'h5A, 1'b0));
      send(image_req(8'h00, 1'b0));
      send(image_req(8'hFF, 1'b0));
      send(image_req(8'hFF, 1'b0));
      send(read_req(0));
      send(read_req(mfb_pkg::ROW_BYTES));
      send(read_req(mfb_pkg::ROW_BYTES + 1));

      // extremes, the second one keeps the counters of the first
      configure(-1024, -1024, 1023, 1023);
      draw_image(1'b1);
      configure(1023, 1023, 1023, 1023);
      draw_image(1'b0);
      configure(mfb_pkg::PANEL_WIDTH - 8, mfb_pkg::PANEL_HEIGHT - 1, 16, 1);
      draw_image(1'b1);
      configure(0, 0, 1023, 1);
      draw_image(1'b1);

      while (sent < ITEM_GOAL)
         random_phase();

      settle();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: mono_framebuffer_blitter_unit.f
rtl/mfb_pkg.sv
rtl/mfb_store.sv
rtl/mfb_merge.sv
rtl/mono_framebuffer_blitter_unit.sv
bench/tb.sv
